// File: hdl/gregorian_date_stepper_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the date stepper checker
// Clocked property wrappers used by the bound checker.
// ----------------------------------------------------------------------------
`ifndef GREGORIAN_DATE_STEPPER_TOP_MACROS_SVH
`define GREGORIAN_DATE_STEPPER_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define GDS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("date stepper check failed");

// next-cycle implication, disabled while reset is low
`define GDS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("date stepper check failed");

`endif

// File: hdl/gds_pkg.sv
// ----------------------------------------------------------------------------
// gds_pkg
// Types, constants and calendar helpers shared by the date stepper.
// ----------------------------------------------------------------------------
package gds_pkg;

  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 16;

  localparam int DELTA_BITS_DEF = 16;

  // default date after reset or a rejected load
  localparam logic [DAY_W-1:0]   DEF_DAY   = 5'd1;
  localparam logic [MONTH_W-1:0] DEF_MONTH = 4'd1;
  localparam logic [YEAR_W-1:0]  DEF_YEAR  = 16'd2023;
  localparam logic               DEF_LEAP  = 1'b0;

  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  // divisibility by 25: y * inv(25) mod 2^16 <= floor(65535 / 25)
  localparam logic [YEAR_W-1:0] INV25     = 16'd23593;
  localparam logic [YEAR_W-1:0] DIV25_MAX = 16'd2621;

  // item kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEAP,
    ST_CHECK,
    ST_STEP,
    ST_DONE
  } gds_state_t;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } gds_date_t;

  // days in a month; out-of-range months report 31
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    if (m == MONTH_FEB) begin
      len = leap ? 5'd29 : 5'd28;
    end else if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP ||
                 m == MONTH_NOV) begin
      len = 5'd30;
    end else begin
      len = 5'd31;
    end
    return len;
  endfunction

endpackage

// File: hdl/gds_leap.sv
// ----------------------------------------------------------------------------
// gds_leap
// Leap year test (rule of 4, 100 and 400) on a 16-bit year.
// ----------------------------------------------------------------------------
module gds_leap (
  input  logic [gds_pkg::YEAR_W-1:0] year_i,
  output logic                       leap_o
);
  import gds_pkg::*;

  logic [YEAR_W-1:0] prod;
  logic              div4;
  logic              div16;
  logic              div25;

  // modular inverse trick for divisibility by 25
  assign prod  = YEAR_W'(year_i * INV25);
  assign div25 = (prod <= DIV25_MAX);
  assign div4  = (year_i[1:0] == 2'b00);
  assign div16 = (year_i[3:0] == 4'b0000);

  // div 400 = div 16 and div 25; div 100 = div 4 and div 25
  assign leap_o = (div16 && div25) || (div4 && !div25);

endmodule

// File: hdl/gds_day_unit.sv
// ----------------------------------------------------------------------------
// gds_day_unit
// Moves a date one day forward or back, rolling month and year.
// ----------------------------------------------------------------------------
module gds_day_unit (
  input  gds_pkg::gds_date_t cur_i,
  input  logic               leap_i,
  input  logic               back_i,
  output gds_pkg::gds_date_t nxt_o,
  output logic               year_chg_o
);
  import gds_pkg::*;

  logic [MONTH_W-1:0] prev_month;

  assign prev_month = (cur_i.month > 4'd1) ? MONTH_W'(cur_i.month - 4'd1) : MONTH_DEC;

  always_comb begin
    nxt_o      = cur_i;
    year_chg_o = 1'b0;
    if (!back_i) begin
      // forward one day
      if (cur_i.day < month_len(cur_i.month, leap_i)) begin
        nxt_o.day = DAY_W'(cur_i.day + 5'd1);
      end else begin
        nxt_o.day = 5'd1;
        if (cur_i.month < MONTH_DEC) begin
          nxt_o.month = MONTH_W'(cur_i.month + 4'd1);
        end else begin
          nxt_o.month = 4'd1;
          nxt_o.year  = YEAR_W'(cur_i.year + 16'd1);
          year_chg_o  = 1'b1;
        end
      end
    end else begin
      // back one day; December is 31 days whatever the year
      if (cur_i.day > 5'd1) begin
        nxt_o.day = DAY_W'(cur_i.day - 5'd1);
      end else begin
        nxt_o.month = prev_month;
        nxt_o.day   = month_len(prev_month, leap_i);
        if (cur_i.month <= 4'd1) begin
          nxt_o.year = YEAR_W'(cur_i.year - 16'd1);
          year_chg_o = 1'b1;
        end
      end
    end
  end

endmodule

// File: hdl/gregorian_date_stepper_top.sv
// ----------------------------------------------------------------------------
// gregorian_date_stepper_top
// Gregorian date register with checked load and day-by-day stepping.
// ----------------------------------------------------------------------------
// A load item passes from acceptance through ST_LEAP, which registers the
// leap flag of the new year, ST_CHECK, which checks the date, and ST_DONE,
// which hands it to the output register once that register is free. A step
// item runs in ST_STEP, where the day unit applies one day per cycle and
// each new year passes through ST_LEAP to refresh the leap flag, until
// |day_delta| days are applied. The input is stalled while an item is in
// work; a result waiting in the output register does not block the next item.
module gregorian_date_stepper_top #(
  parameter int DELTA_BITS = gds_pkg::DELTA_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_kind,
  input  logic [gds_pkg::DAY_W-1:0]    in_load_day,
  input  logic [gds_pkg::MONTH_W-1:0]  in_load_month,
  input  logic [gds_pkg::YEAR_W-1:0]   in_load_year,
  input  logic signed [DELTA_BITS-1:0] in_day_delta,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [gds_pkg::DAY_W-1:0]    out_day,
  output logic [gds_pkg::MONTH_W-1:0]  out_month,
  output logic [gds_pkg::YEAR_W-1:0]   out_year,
  output logic                         out_load_ok
);
  import gds_pkg::*;

  gds_state_t state_r, state_nxt;

  gds_date_t             cur_r, cur_nxt;
  logic                  leap_r, leap_nxt;
  logic                  kind_r, kind_nxt;
  logic                  back_r, back_nxt;
  logic                  ok_r, ok_nxt;
  logic [DELTA_BITS-1:0] cnt_r, cnt_nxt;

  gds_date_t out_date_r;
  logic      out_ok_r;
  logic      out_valid_r, out_valid_nxt;

  logic      in_acc;
  logic      leap_w;
  gds_date_t step_date;
  logic      year_chg;
  logic      date_ok;
  logic      cnt_zero;
  logic      out_load;

  gds_leap u_leap (
    .year_i (cur_r.year),
    .leap_o (leap_w)
  );

  gds_day_unit u_day (
    .cur_i      (cur_r),
    .leap_i     (leap_r),
    .back_i     (back_r),
    .nxt_o      (step_date),
    .year_chg_o (year_chg)
  );

  assign in_acc   = in_valid && !in_stall;
  assign cnt_zero = (cnt_r == '0);
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);
  assign date_ok  = (cur_r.month >= 4'd1) && (cur_r.month <= MONTH_DEC) &&
                    (cur_r.day != 5'd0) &&
                    (cur_r.day <= month_len(cur_r.month, leap_r));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_acc) begin
        state_nxt = (in_kind == KIND_LOAD) ? ST_LEAP : ST_STEP;
      end
      ST_LEAP:  state_nxt = (kind_r == KIND_LOAD) ? ST_CHECK : ST_STEP;
      ST_CHECK: state_nxt = ST_DONE;
      ST_STEP:  begin
        if (cnt_zero) begin
          state_nxt = ST_DONE;
        end else if (year_chg) begin
          state_nxt = ST_LEAP;
        end
      end
      ST_DONE:  if (out_load) begin
        state_nxt = ST_IDLE;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // datapath updates per state
  always_comb begin
    cur_nxt  = cur_r;
    leap_nxt = leap_r;
    kind_nxt = kind_r;
    back_nxt = back_r;
    ok_nxt   = ok_r;
    cnt_nxt  = cnt_r;
    unique case (state_r)
      ST_IDLE:  if (in_acc) begin
        kind_nxt = in_kind;
        ok_nxt   = 1'b1;
        if (in_kind == KIND_LOAD) begin
          cur_nxt.day   = in_load_day;
          cur_nxt.month = in_load_month;
          cur_nxt.year  = in_load_year;
        end else begin
          back_nxt = in_day_delta[DELTA_BITS-1];
          cnt_nxt  = in_day_delta[DELTA_BITS-1] ? $unsigned(-in_day_delta)
                                                : $unsigned(in_day_delta);
        end
      end
      ST_LEAP:  leap_nxt = leap_w;
      ST_CHECK: if (!date_ok) begin
        cur_nxt.day   = DEF_DAY;
        cur_nxt.month = DEF_MONTH;
        cur_nxt.year  = DEF_YEAR;
        leap_nxt      = DEF_LEAP;
        ok_nxt        = 1'b0;
      end
      ST_STEP:  if (!cnt_zero) begin
        cur_nxt = step_date;
        cnt_nxt = DELTA_BITS'(cnt_r - 1'b1);
      end
      ST_DONE:  ;
      default:  ;
    endcase
  end

  // output register handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      cur_r.day     <= DEF_DAY;
      cur_r.month   <= DEF_MONTH;
      cur_r.year    <= DEF_YEAR;
      leap_r        <= DEF_LEAP;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      leap_r      <= leap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // item and result payload registers
  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    back_r <= back_nxt;
    ok_r   <= ok_nxt;
    cnt_r  <= cnt_nxt;
    if (out_load) begin
      out_date_r <= cur_r;
      out_ok_r   <= ok_r;
    end
  end

  assign in_stall    = (state_r != ST_IDLE);
  assign out_valid   = out_valid_r;
  assign out_day     = out_date_r.day;
  assign out_month   = out_date_r.month;
  assign out_year    = out_date_r.year;
  assign out_load_ok = out_ok_r;

endmodule

// File: hdl/gds_checker.sv
// ----------------------------------------------------------------------------
// gds_checker
// Port-level checks on the date stepper, bound to the top level.
// ----------------------------------------------------------------------------
`include "gregorian_date_stepper_top_macros.svh"

module gds_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [gds_pkg::DAY_W-1:0]   out_day,
  input logic [gds_pkg::MONTH_W-1:0] out_month,
  input logic [gds_pkg::YEAR_W-1:0]  out_year,
  input logic                        out_load_ok
);
  import gds_pkg::*;

  // a stalled result holds
  `GDS_ASSERT_NXT(a_out_hold, out_valid && out_stall,
                  out_valid && $stable(out_day) && $stable(out_month) &&
                  $stable(out_year) && $stable(out_load_ok))

  // the block is busy right after taking an item
  `GDS_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  // every reported date has a nonzero day and a month in range
  `GDS_ASSERT_IMP(a_date_range, out_valid,
                  out_day != 5'd0 && out_month >= 4'd1 && out_month <= MONTH_DEC)

  // a rejected load reports the default date
  `GDS_ASSERT_IMP(a_reject_default, out_valid && !out_load_ok,
                  out_day == DEF_DAY && out_month == DEF_MONTH && out_year == DEF_YEAR)

endmodule

bind gregorian_date_stepper_top gds_checker u_gds_checker (.*);

// File: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: date stepper testbench
// Loads dates, valid and invalid, and steps them by signed day counts.
// A software calendar predicts each result. Both channels idle and stall
// at random, and every result is checked field by field in order.
// ----------------------------------------------------------------------------
module tb;
  import gds_pkg::*;

  typedef struct packed {
    gds_date_t date;
    logic      ok;
  } date_result_t;

  // Calendar kept in step with the block; queues the dates it owes.
  class date_tracker;
    gds_date_t    now;
    date_result_t owed_dates[$];
    int           errors;

    function new();
      now.day   = DEF_DAY;
      now.month = DEF_MONTH;
      now.year  = DEF_YEAR;
      errors    = 0;
    endfunction

    static function logic leap(logic [YEAR_W-1:0] y);
      return ((y % 400) == 0) || (((y % 100) != 0) && ((y % 4) == 0));
    endfunction

    static function logic [DAY_W-1:0] days_in(logic [MONTH_W-1:0] m,
                                              logic [YEAR_W-1:0] y);
      logic [DAY_W-1:0] n;
      case (m)
        MONTH_FEB: n = leap(y) ? 5'd29 : 5'd28;
        MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: n = 5'd30;
        default: n = 5'd31;
      endcase
      return n;
    endfunction

    function void next_day();
      if (now.day < days_in(now.month, now.year)) begin
        now.day = now.day + 1'b1;
      end else begin
        now.day = 5'd1;
        if (now.month < MONTH_DEC) begin
          now.month = now.month + 1'b1;
        end else begin
          // year wraps at 16 bits
          now.month = 4'd1;
          now.year  = now.year + 1'b1;
        end
      end
    endfunction

    function void prev_day();
      if (now.day > 5'd1) begin
        now.day = now.day - 1'b1;
      end else begin
        if (now.month > 4'd1) begin
          now.month = now.month - 1'b1;
        end else begin
          now.month = MONTH_DEC;
          now.year  = now.year - 1'b1;
        end
        now.day = days_in(now.month, now.year);
      end
    endfunction

    // accepted input item: work out the date it leaves behind
    function void note_item(logic kind, logic [DAY_W-1:0] d, logic [MONTH_W-1:0] m,
                            logic [YEAR_W-1:0] y, logic signed [DELTA_BITS_DEF-1:0] delta);
      date_result_t r;
      int           steps;
      r.ok = 1'b1;
      if (kind == KIND_LOAD) begin
        if (m >= 4'd1 && m <= MONTH_DEC && d >= 5'd1 && d <= days_in(m, y)) begin
          now.day   = d;
          now.month = m;
          now.year  = y;
        end else begin
          now.day   = DEF_DAY;
          now.month = DEF_MONTH;
          now.year  = DEF_YEAR;
          r.ok      = 1'b0;
        end
      end else begin
        steps = delta;
        if (steps < 0) begin
          repeat (-steps) prev_day();
        end else begin
          repeat (steps) next_day();
        end
      end
      r.date = now;
      owed_dates.push_back(r);
    endfunction

    function int pending();
      return owed_dates.size();
    endfunction

    task report(string msg);
      $display("[%0t] date mismatch: %s", $time, msg);
      errors++;
    endtask

    // accepted result: compare with the oldest owed date
    task check_result(gds_date_t got, logic ok);
      date_result_t want;
      if (owed_dates.size() == 0) begin
        report($sformatf("result %0d/%0d/%0d with no item pending",
                         got.day, got.month, got.year));
      end else begin
        want = owed_dates.pop_front();
        if (got.day !== want.date.day)
          report($sformatf("day got %0d expected %0d", got.day, want.date.day));
        if (got.month !== want.date.month)
          report($sformatf("month got %0d expected %0d", got.month, want.date.month));
        if (got.year !== want.date.year)
          report($sformatf("year got %0d expected %0d", got.year, want.date.year));
        if (ok !== want.ok)
          report($sformatf("load_ok got %0b expected %0b", ok, want.ok));
      end
    endtask
  endclass

  logic                             clk = 1'b0;
  logic                             rst_n;
  logic                             in_valid;
  logic                             in_stall;
  logic                             in_kind;
  logic [DAY_W-1:0]                 in_load_day;
  logic [MONTH_W-1:0]               in_load_month;
  logic [YEAR_W-1:0]                in_load_year;
  logic signed [DELTA_BITS_DEF-1:0] in_day_delta;
  logic                             out_valid;
  logic                             out_stall;
  logic [DAY_W-1:0]                 out_day;
  logic [MONTH_W-1:0]               out_month;
  logic [YEAR_W-1:0]                out_year;
  logic                             out_load_ok;

  date_tracker calendar = new();
  int          sent_count  = 0;
  int          taken_count = 0;
  int          next_gap;

  gregorian_date_stepper_top u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_load_day  (in_load_day),
    .in_load_month(in_load_month),
    .in_load_year (in_load_year),
    .in_day_delta (in_day_delta),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_day      (out_day),
    .out_month    (out_month),
    .out_year     (out_year),
    .out_load_ok  (out_load_ok)
  );

  always #10 clk = ~clk;

  // random waits, with every fourth run of ten items not waiting at all
  function automatic int pick_wait(int n);
    if (((n / 10) % 4) == 3) return 0;
    return $urandom_range(0, 14);
  endfunction

  // present one item and hold it until taken
  task automatic send_item(logic kind, logic [DAY_W-1:0] d, logic [MONTH_W-1:0] m,
                           logic [YEAR_W-1:0] y, logic signed [DELTA_BITS_DEF-1:0] delta);
    repeat (next_gap) @(posedge clk);
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_load_day   <= d;
    in_load_month <= m;
    in_load_year  <= y;
    in_day_delta  <= delta;
    do @(posedge clk); while (in_stall);
    calendar.note_item(kind, d, m, y, delta);
    sent_count++;
    next_gap = pick_wait(sent_count);
    if (next_gap > 0) in_valid <= 1'b0;
  endtask

  task automatic send_load(logic [DAY_W-1:0] d, logic [MONTH_W-1:0] m,
                           logic [YEAR_W-1:0] y);
    send_item(KIND_LOAD, d, m, y, DELTA_BITS_DEF'($urandom));
  endtask

  task automatic send_step(logic signed [DELTA_BITS_DEF-1:0] delta);
    send_item(KIND_STEP, DAY_W'($urandom), MONTH_W'($urandom), YEAR_W'($urandom), delta);
  endtask

  // mostly valid dates, biased to month ends and century years
  task automatic send_random_load();
    logic [MONTH_W-1:0] m;
    logic [YEAR_W-1:0]  y;
    logic [DAY_W-1:0]   d;
    if ($urandom_range(0, 6) == 0) begin
      send_load(DAY_W'($urandom), MONTH_W'($urandom), YEAR_W'($urandom));
    end else begin
      m = MONTH_W'($urandom_range(1, 12));
      case ($urandom_range(0, 3))
        0: y = YEAR_W'(100 * $urandom_range(0, 655));
        1: y = $urandom_range(0, 1) ? YEAR_W'($urandom_range(0, 2))
                                    : YEAR_W'($urandom_range(65533, 65535));
        default: y = YEAR_W'($urandom);
      endcase
      d = $urandom_range(0, 1) ? date_tracker::days_in(m, y)
                               : DAY_W'($urandom_range(1, date_tracker::days_in(m, y)));
      send_load(d, m, y);
    end
  endtask

  // hold off input until every owed date has come back
  task automatic wait_idle();
    if (next_gap == 0) in_valid <= 1'b0;
    while (calendar.pending() != 0) @(posedge clk);
  endtask

  // result side: random stall per item, then take and check
  initial begin
    int hold;
    forever begin
      hold = pick_wait(taken_count + 5);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(rst_n && out_valid && !out_stall));
      calendar.check_result('{day: out_day, month: out_month, year: out_year}, out_load_ok);
      taken_count++;
    end
  end

  // stimulus
  initial begin
    logic signed [DELTA_BITS_DEF-1:0] delta;
    int                               span;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_kind       <= KIND_LOAD;
    in_load_day   <= '0;
    in_load_month <= '0;
    in_load_year  <= '0;
    in_day_delta  <= '0;
    next_gap = pick_wait(0);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // zero step from the reset date
    send_step(16'sd0);
    // year wrap both ways
    send_load(5'd31, MONTH_DEC, 16'd65535);
    send_step(16'sd1);
    send_step(-16'sd1);
    // year 0 is a leap year
    send_load(5'd28, MONTH_FEB, 16'd0);
    send_step(16'sd1);
    // leap rule: century, 400-year, common and ordinary leap years
    send_load(5'd29, MONTH_FEB, 16'd1900);
    send_load(5'd29, MONTH_FEB, 16'd2000);
    send_load(5'd29, MONTH_FEB, 16'd2023);
    send_load(5'd29, MONTH_FEB, 16'd2024);
    send_step(16'sd1);
    send_step(-16'sd1);
    // loads: day zero, month out of range, day past month end, then valid month ends
    send_load(5'd0, 4'd5, 16'd2023);
    send_load(5'd10, 4'd0, 16'd2023);
    send_load(5'd1, 4'd13, 16'd2023);
    send_load(5'd31, 4'd15, 16'd65535);
    send_load(5'd31, MONTH_APR, 16'd2023);
    send_load(5'd30, MONTH_APR, 16'd2023);
    send_load(5'd31, 4'd1, 16'd2023);
    // widest steps each way
    send_step(16'sh7fff);
    send_step(16'sh8000);
    wait_idle();

    // random part; the wide steps are kept to a few
    for (int i = 0; i < 100; i++) begin
      if (i == 50) wait_idle();
      if ((i % 25) == 12) begin
        send_step(DELTA_BITS_DEF'($urandom));
      end else if ($urandom_range(0, 9) < 4) begin
        send_random_load();
      end else begin
        span  = ($urandom_range(0, 3) == 0) ? 3 : 400;
        delta = DELTA_BITS_DEF'($urandom_range(0, span));
        if ($urandom_range(0, 1)) delta = -delta;
        send_step(delta);
      end
    end

    wait_idle();
    repeat (50) @(posedge clk);
    if (calendar.errors == 0 && calendar.pending() == 0) begin
      $display("[gregorian_date_stepper_top] OK");
    end else begin
      $display("[gregorian_date_stepper_top] ERROR");
    end
    $finish;
  end

  // run limit, several times the slowest expected run
  initial begin
    #25_000_000;
    $display("[gregorian_date_stepper_top] ERROR");
    $finish;
  end

endmodule
